[hw/rtl/rsmp_pkg.sv]
// Shared types and constants for the 2-to-3 linear resampler.
package rsmp_pkg;

   localparam int SampleWidth = 16;
   localparam int SumWidth    = SampleWidth + 2;
   localparam int MagWidth    = SampleWidth + 1;
   localparam int RecipShift  = 18;
   localparam int ProdWidth   = 2 * MagWidth;
   // ceil(2^18 / 3); exact for magnitudes below 2^17
   localparam logic [MagWidth-1:0] RECIP3 = 17'd87382;

   localparam logic [1:0] CNT_ONE = 2'd1;

   typedef struct packed {
      logic signed [SampleWidth-1:0] in_sample;
      logic                          in_last;
   } req_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] out_sample;
      logic                          run_end;
      logic                          stream_end;
   } rsp_type;

   // accepted sample plus the stream state seen at its transfer
   typedef struct packed {
      logic signed [SampleWidth-1:0] cur;
      logic signed [SampleWidth-1:0] prev;
      logic                          last;
      logic                          odd;
      logic                          started;
   } stage_type;

   // results of one item: first value, then cur repeated; cnt is 1 to 3
   typedef struct packed {
      logic signed [SampleWidth-1:0] first;
      logic signed [SampleWidth-1:0] cur;
      logic [1:0]                    cnt;
      logic                          last;
   } burst_type;

endpackage

[hw/rtl/rsmp_calc.sv]
// Weighted mean by one third and result count for one accepted sample.
module rsmp_calc (
   input  rsmp_pkg::stage_type stage,
   output rsmp_pkg::burst_type burst
);

   logic signed [rsmp_pkg::SumWidth-1:0]  prev_ext;
   logic signed [rsmp_pkg::SumWidth-1:0]  cur_ext;
   logic signed [rsmp_pkg::SumWidth-1:0]  sum;
   logic signed [rsmp_pkg::SumWidth-1:0]  sum_neg;
   logic [rsmp_pkg::MagWidth-1:0]         mag;
   logic [rsmp_pkg::ProdWidth-1:0]        prod;
   logic [rsmp_pkg::SampleWidth-1:0]      qmag;
   logic signed [rsmp_pkg::SampleWidth-1:0] mean;
   logic [1:0]                            cnt;

   always_comb begin
      prev_ext = rsmp_pkg::SumWidth'(stage.prev);
      cur_ext  = rsmp_pkg::SumWidth'(stage.cur);
      if (stage.odd) begin
         sum = prev_ext + (cur_ext <<< 1);
      end else begin
         sum = (prev_ext <<< 1) + cur_ext;
      end
      sum_neg = -sum;
      // truncation toward zero: divide the magnitude, then restore sign
      mag  = sum[rsmp_pkg::SumWidth-1] ? sum_neg[rsmp_pkg::MagWidth-1:0]
                                       : sum[rsmp_pkg::MagWidth-1:0];
      prod = rsmp_pkg::ProdWidth'(mag) * rsmp_pkg::ProdWidth'(rsmp_pkg::RECIP3);
      qmag = prod[rsmp_pkg::RecipShift +: rsmp_pkg::SampleWidth];
      mean = sum[rsmp_pkg::SumWidth-1] ? $signed(-qmag) : $signed(qmag);

      cnt = rsmp_pkg::CNT_ONE;
      if (stage.started && !stage.odd) begin
         cnt = cnt + 2'd1;
      end
      if (stage.last) begin
         cnt = cnt + 2'd1;
      end

      burst.first = stage.started ? mean : stage.cur;
      burst.cur   = stage.cur;
      burst.cnt   = cnt;
      burst.last  = stage.last;
   end

endmodule

[hw/rtl/rsmp_emit.sv]
// Result register that plays out the one to three results of an item.
module rsmp_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  rsmp_pkg::burst_type burst,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsmp_pkg::rsp_type   rsp_data
);

   logic                valid_ff, valid_in;
   rsmp_pkg::burst_type item_ff, item_in;
   logic [1:0]          idx_ff, idx_in;
   logic                final_res;
   logic                xfer;

   assign final_res = (idx_ff + 2'd1) == item_ff.cnt;
   assign xfer      = valid_ff && rsp_ready;
   assign free      = !valid_ff || (rsp_ready && final_res);

   assign rsp_valid           = valid_ff;
   assign rsp_data.out_sample = (idx_ff == 2'd0) ? item_ff.first : item_ff.cur;
   assign rsp_data.run_end    = final_res;
   assign rsp_data.stream_end = final_res && item_ff.last;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = burst;
         idx_in   = 2'd0;
      end else if (xfer) begin
         if (final_res) begin
            valid_in = 1'b0;
         end
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      item_ff <= item_in;
   end

   a_end_implies_run: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_data.stream_end) |-> rsp_data.run_end)
      else $error("stream end flagged on a non-final result");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < item_ff.cnt))
      else $error("result index past the item's count");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (xfer && !final_res) |=> (valid_ff && idx_ff == $past(idx_ff) + 2'd1))
      else $error("burst dropped before its final result");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("item loaded over a pending result");

endmodule

[hw/rtl/linear_resampler_2_to_3.sv]
// A sample passes the input stage, then the result register, to the port.
// Throughput: one sample per cycle if each gives one result, taken at once;
// overall the result port paces it, one result per cycle, 3 per 2 samples.
// A sample gives 1 to 3 results; the next sample waits in the input stage.
// Reset (synchronous, active high) clears the stream state and all valids.
// Top level of the 2-to-3 linear resampler: input stage and stream state.
module linear_resampler_2_to_3 (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rsmp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsmp_pkg::rsp_type rsp_data
);

   logic signed [rsmp_pkg::SampleWidth-1:0] held_ff, held_in;
   logic                odd_ff, odd_in;
   logic                started_ff, started_in;
   logic                stg_valid_ff, stg_valid_in;
   rsmp_pkg::stage_type stg_ff, stg_in;
   rsmp_pkg::burst_type burst;
   logic                emit_free;
   logic                move;
   logic                accept;

   assign move      = stg_valid_ff && emit_free;
   assign req_ready = !stg_valid_ff || emit_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      held_in      = held_ff;
      odd_in       = odd_ff;
      started_in   = started_ff;
      stg_valid_in = stg_valid_ff;
      stg_in       = stg_ff;
      if (move) begin
         stg_valid_in = 1'b0;
      end
      if (accept) begin
         stg_valid_in   = 1'b1;
         stg_in.cur     = req_data.in_sample;
         stg_in.prev    = held_ff;
         stg_in.last    = req_data.in_last;
         stg_in.odd     = odd_ff;
         stg_in.started = started_ff;
         if (req_data.in_last) begin
            held_in    = '0;
            odd_in     = 1'b0;
            started_in = 1'b0;
         end else begin
            held_in    = req_data.in_sample;
            odd_in     = !odd_ff;
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         odd_ff       <= 1'b0;
         started_ff   <= 1'b0;
         stg_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         odd_ff       <= odd_in;
         started_ff   <= started_in;
         stg_valid_ff <= stg_valid_in;
      end
      stg_ff <= stg_in;
   end

   rsmp_calc u_calc (
      .stage (stg_ff),
      .burst (burst)
   );

   rsmp_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (move),
      .burst     (burst),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.in_last) |=> (!started_ff && !odd_ff && held_ff == '0))
      else $error("stream state not cleared after last sample");

   a_odd_needs_start: assert property (@(posedge clock) disable iff (reset)
      odd_ff |-> started_ff)
      else $error("odd phase outside a stream");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the 2-to-3 linear resampler.
module testbench;

   typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_type;

   localparam int CycleLimit = 200_000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   rsmp_pkg::req_type req_data  = '0;
   logic              rsp_ready = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   rsmp_pkg::rsp_type rsp_data;

   // predicted stream state
   int   held_sample    = 0;
   logic odd_phase      = 1'b0;
   logic stream_started = 1'b0;

   rsmp_pkg::rsp_type expected_outputs[$];
   rsmp_pkg::rsp_type oldest_output;
   int                error_count  = 0;
   int                cycle_count  = 0;
   int                burst_left   = 0;
   logic              gaps_enabled = 1'b1;
   ready_mode_type    ready_mode   = READY_ALWAYS;
   int                hold_cycles  = 0;
   logic [7:0]        ready_pattern = 8'b1011_0110;

   linear_resampler_2_to_3 u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // expected outputs of one accepted sample, then the state update
   task automatic predict_resample(input rsmp_pkg::req_type item);
      int cur;
      int vals[3];
      int n;
      rsmp_pkg::rsp_type r;
      cur = item.in_sample;
      n = 0;
      if (!stream_started) begin
         vals[n] = cur;
         n++;
      end else if (odd_phase) begin
         vals[n] = (held_sample + 2 * cur) / 3;
         n++;
      end else begin
         vals[n]     = (2 * held_sample + cur) / 3;
         vals[n + 1] = cur;
         n += 2;
      end
      if (item.in_last) begin
         vals[n] = cur;
         n++;
      end
      for (int k = 0; k < n; k++) begin
         r.out_sample = 16'(vals[k]);
         r.run_end    = (k == n - 1);
         r.stream_end = (k == n - 1) && item.in_last;
         expected_outputs.push_back(r);
      end
      if (item.in_last) begin
         held_sample    = 0;
         odd_phase      = 1'b0;
         stream_started = 1'b0;
      end else begin
         held_sample    = cur;
         odd_phase      = !odd_phase;
         stream_started = 1'b1;
      end
   endtask

   // output checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output %0d", rsp_data.out_sample));
         end else begin
            oldest_output = expected_outputs.pop_front();
            if (rsp_data.out_sample !== oldest_output.out_sample)
               report_mismatch($sformatf("out_sample got %0d want %0d",
                  rsp_data.out_sample, oldest_output.out_sample));
            if (rsp_data.run_end !== oldest_output.run_end)
               report_mismatch($sformatf("run_end got %b want %b",
                  rsp_data.run_end, oldest_output.run_end));
            if (rsp_data.stream_end !== oldest_output.stream_end)
               report_mismatch($sformatf("stream_end got %b want %b",
                  rsp_data.stream_end, oldest_output.stream_end));
         end
      end
   end

   // output-side stalls; a requested hold drives ready low, then clears hold_cycles
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: begin
               rsp_ready <= ready_pattern[0];
               ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            end
         endcase
      end
   end

   // one input transfer; valid stays high across back-to-back samples of a burst
   task automatic send_sample(input logic signed [15:0] sample, input logic last);
      rsmp_pkg::req_type item;
      item.in_sample = sample;
      item.in_last   = last;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_enabled) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_resample(item);
   endtask

   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_outputs.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($signed($urandom_range(0, 8)) - 4);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_stream(input int len);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(), i == len - 1);
   endtask

   task automatic test_single_sample_streams();
      ready_mode   = READY_ALWAYS;
      gaps_enabled = 1'b0;
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh0000, 1'b1);
      drain_outputs();
   endtask

   task automatic test_extreme_values();
      ready_mode   = READY_RANDOM;
      gaps_enabled = 1'b1;
      // odd-length end: two results from the final sample
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      // even-index last that is not the first: three results
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      // small negatives: quotients truncate toward zero
      send_sample(16'sh0001, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd2, 1'b0);
      send_sample(-16'sd1, 1'b1);
      // alternating bit patterns
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b0);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b1);
      drain_outputs();
   endtask

   task automatic test_random_streams(input int items);
      int len;
      int sent;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
         ready_mode   = ready_mode_type'($urandom_range(0, 2));
         gaps_enabled = ($urandom_range(0, 9) < 7);
         send_stream(len);
         sent += len;
         if ($urandom_range(0, 4) == 0)
            drain_outputs();
      end
      drain_outputs();
   endtask

   // long output hold while the input keeps offering: the block must fill and stall
   task automatic test_output_backpressure();
      ready_mode   = READY_ALWAYS;
      gaps_enabled = 1'b0;
      hold_cycles  = 300;
      send_stream(24);
      drain_outputs();
      ready_mode   = READY_RANDOM;
      hold_cycles  = 150;
      send_stream(17);
      drain_outputs();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_sample_streams();
      test_extreme_values();
      test_random_streams(250);
      test_output_backpressure();
      drain_outputs();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
